// ----- design/nlp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants of the next lexicographic permutation core.
// ----------------------------------------------------------------------------
package nlp_pkg;

  // Width of an element as it travels on the stream ports.
  localparam int VALUE_W = 16;

  // Operations that the controller asks of the datapath in one cycle.
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_PV_FIRST = 4'd2,
    OP_PV_LOAD  = 4'd3,
    OP_PV_CMP   = 4'd4,
    OP_SC_CMP   = 4'd5,
    OP_SW1      = 4'd6,
    OP_SW2      = 4'd7,
    OP_RV_A     = 4'd8,
    OP_RV_B     = 4'd9,
    OP_RV_C     = 4'd10,
    OP_RV_D     = 4'd11,
    OP_EM_INIT  = 4'd12,
    OP_EM_RD    = 4'd13,
    OP_EM_LD    = 4'd14
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic short_seq;  // the buffer is empty, so a closing request leaves one element
    logic pv_lt;      // element just read is below the one after it
    logic sc_gt;      // element just read is above the pivot
    logic idx_zero;   // scan index has reached the head of the buffer
    logic lo_lt_hi;   // reversal pointers have not yet met
    logic em_last;    // emit pointer is on the final element
    logic slot_free;  // output register is empty or being taken
  } dp_stat_t;

endpackage

// ----- design/nlp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/nlp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_ctrl
// Sequencer for load, pivot scan, successor scan, swap, reversal and emit.
// ----------------------------------------------------------------------------
module nlp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  input  nlp_pkg::dp_stat_t stat,
  output nlp_pkg::dp_cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_LOAD     = 13'b0000000000001,
    S_PV_FIRST = 13'b0000000000010,
    S_PV_LOAD  = 13'b0000000000100,
    S_PV_CMP   = 13'b0000000001000,
    S_SC_CMP   = 13'b0000000010000,
    S_SW1      = 13'b0000000100000,
    S_SW2      = 13'b0000001000000,
    S_RV_A     = 13'b0000010000000,
    S_RV_B     = 13'b0000100000000,
    S_RV_C     = 13'b0001000000000,
    S_RV_D     = 13'b0010000000000,
    S_EM_RD    = 13'b0100000000000,
    S_EM_LD    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = nlp_pkg::OP_NONE;
    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          cmd.op = nlp_pkg::OP_LOAD;
          if (in_tlast) begin
            state_nxt = stat.short_seq ? S_EM_RD : S_PV_FIRST;
          end
        end
      end
      S_PV_FIRST: begin
        cmd.op    = nlp_pkg::OP_PV_FIRST;
        state_nxt = S_PV_LOAD;
      end
      S_PV_LOAD: begin
        cmd.op    = nlp_pkg::OP_PV_LOAD;
        state_nxt = S_PV_CMP;
      end
      S_PV_CMP: begin
        cmd.op = nlp_pkg::OP_PV_CMP;
        if (stat.pv_lt) begin
          state_nxt = S_SC_CMP;
        end else if (stat.idx_zero) begin
          state_nxt = S_RV_A;
        end
      end
      S_SC_CMP: begin
        cmd.op = nlp_pkg::OP_SC_CMP;
        if (stat.sc_gt) begin
          state_nxt = S_SW1;
        end
      end
      S_SW1: begin
        cmd.op    = nlp_pkg::OP_SW1;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        cmd.op    = nlp_pkg::OP_SW2;
        state_nxt = S_RV_A;
      end
      S_RV_A: begin
        if (stat.lo_lt_hi) begin
          cmd.op    = nlp_pkg::OP_RV_A;
          state_nxt = S_RV_B;
        end else begin
          cmd.op    = nlp_pkg::OP_EM_INIT;
          state_nxt = S_EM_RD;
        end
      end
      S_RV_B: begin
        cmd.op    = nlp_pkg::OP_RV_B;
        state_nxt = S_RV_C;
      end
      S_RV_C: begin
        cmd.op    = nlp_pkg::OP_RV_C;
        state_nxt = S_RV_D;
      end
      S_RV_D: begin
        cmd.op    = nlp_pkg::OP_RV_D;
        state_nxt = S_RV_A;
      end
      S_EM_RD: begin
        if (stat.slot_free) begin
          cmd.op    = nlp_pkg::OP_EM_RD;
          state_nxt = S_EM_LD;
        end
      end
      S_EM_LD: begin
        cmd.op    = nlp_pkg::OP_EM_LD;
        state_nxt = stat.em_last ? S_LOAD : S_EM_RD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/nlp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_datapath
// Element buffer, scan pointers, compare logic and output register.
// ----------------------------------------------------------------------------
module nlp_datapath #(
  parameter int MAX_LEN    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nlp_pkg::dp_cmd_t             cmd,
  output nlp_pkg::dp_stat_t            stat,
  input  logic [nlp_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nlp_pkg::VALUE_W-1:0]  out_value,
  output logic                         out_last,
  output logic                         out_found,
  output logic                         out_ovf
);

  localparam int AW    = $clog2(MAX_LEN);
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int EXT_W = (ELEM_WIDTH > nlp_pkg::VALUE_W) ? ELEM_WIDTH : nlp_pkg::VALUE_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

  logic [CW-1:0]         count_r;
  logic                  ovf_r;
  logic                  out_valid_r;
  logic [AW-1:0]         idx_r, piv_idx_r, lo_r, hi_r;
  logic [ELEM_WIDTH-1:0] hold_r, piv_val_r;
  logic                  found_r;
  logic [nlp_pkg::VALUE_W-1:0] out_value_r;
  logic                  out_last_r, out_found_r, out_ovf_r;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [ELEM_WIDTH-1:0] wdata, rd_data, in_elem;
  logic [EXT_W-1:0]      in_ext, rd_ext;
  logic [CW-1:0]         count_dec;
  logic [AW-1:0]         nm1, idx_dec;
  logic                  has_room;

  nlp_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (MAX_LEN)
  ) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Stored values keep ELEM_WIDTH bits; the ports carry VALUE_W bits.
  assign in_ext    = EXT_W'(in_value);
  assign in_elem   = in_ext[ELEM_WIDTH-1:0];
  assign rd_ext    = EXT_W'(rd_data);
  assign count_dec = count_r - CW'(1);
  assign nm1       = count_dec[AW-1:0];
  assign idx_dec   = idx_r - AW'(1);
  assign has_room  = (count_r < MAX_C);

  assign stat.short_seq = (count_r == '0);
  assign stat.pv_lt     = (rd_data < hold_r);
  assign stat.sc_gt     = (piv_val_r < rd_data);
  assign stat.idx_zero  = (idx_r == '0);
  assign stat.lo_lt_hi  = (lo_r < hi_r);
  assign stat.em_last   = (lo_r == nm1);
  assign stat.slot_free = !out_valid_r || out_ready;

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = hold_r;
    raddr = idx_r;
    case (cmd.op)
      nlp_pkg::OP_LOAD: begin
        we    = has_room;
        waddr = count_r[AW-1:0];
        wdata = in_elem;
      end
      nlp_pkg::OP_PV_FIRST: raddr = nm1;
      nlp_pkg::OP_PV_LOAD:  raddr = idx_dec;
      nlp_pkg::OP_PV_CMP:   raddr = stat.pv_lt ? nm1 : idx_dec;
      nlp_pkg::OP_SC_CMP:   raddr = idx_dec;
      nlp_pkg::OP_SW1: begin
        we    = 1'b1;
        waddr = piv_idx_r;
        wdata = hold_r;
      end
      nlp_pkg::OP_SW2: begin
        we    = 1'b1;
        waddr = idx_r;
        wdata = piv_val_r;
      end
      nlp_pkg::OP_RV_A: raddr = lo_r;
      nlp_pkg::OP_RV_B: raddr = hi_r;
      nlp_pkg::OP_RV_C: begin
        we    = 1'b1;
        waddr = lo_r;
        wdata = rd_data;
      end
      nlp_pkg::OP_RV_D: begin
        we    = 1'b1;
        waddr = hi_r;
        wdata = hold_r;
      end
      nlp_pkg::OP_EM_RD: raddr = lo_r;
      default: begin
      end
    endcase
  end

  // Control state: element count, overflow mark and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        nlp_pkg::OP_LOAD: begin
          if (has_room) begin
            count_r <= count_r + CW'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end
        nlp_pkg::OP_EM_LD: begin
          out_valid_r <= 1'b1;
          if (stat.em_last) begin
            count_r <= '0;
            ovf_r   <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pointers, held values and output payload.
  always_ff @(posedge clk) begin
    case (cmd.op)
      nlp_pkg::OP_LOAD: begin
        lo_r    <= '0;
        found_r <= 1'b0;
      end
      nlp_pkg::OP_PV_FIRST: idx_r <= nm1;
      nlp_pkg::OP_PV_LOAD: begin
        hold_r <= rd_data;
        idx_r  <= idx_dec;
      end
      nlp_pkg::OP_PV_CMP: begin
        if (stat.pv_lt) begin
          piv_idx_r <= idx_r;
          piv_val_r <= rd_data;
          found_r   <= 1'b1;
          idx_r     <= nm1;
        end else begin
          hold_r <= rd_data;
          if (stat.idx_zero) begin
            // Sequence never rises anywhere: reverse all of it.
            lo_r <= '0;
            hi_r <= nm1;
          end else begin
            idx_r <= idx_dec;
          end
        end
      end
      nlp_pkg::OP_SC_CMP: begin
        if (stat.sc_gt) begin
          hold_r <= rd_data;
        end else begin
          idx_r <= idx_dec;
        end
      end
      nlp_pkg::OP_SW2: begin
        lo_r <= piv_idx_r + AW'(1);
        hi_r <= nm1;
      end
      nlp_pkg::OP_RV_B: hold_r <= rd_data;
      nlp_pkg::OP_RV_D: begin
        lo_r <= lo_r + AW'(1);
        hi_r <= hi_r - AW'(1);
      end
      nlp_pkg::OP_EM_INIT: lo_r <= '0;
      nlp_pkg::OP_EM_LD: begin
        out_value_r <= rd_ext[nlp_pkg::VALUE_W-1:0];
        out_last_r  <= stat.em_last;
        out_found_r <= found_r;
        out_ovf_r   <= ovf_r;
        lo_r        <= lo_r + AW'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_found = out_found_r;
  assign out_ovf   = out_ovf_r;

endmodule

// ----- design/next_lexicographic_permutation_core.sv -----
`timescale 1ns / 1ps
// Operation: each element request is loaded as it is taken. After a closing request that
//   ends a sequence of two or more, the core scans for the pivot and, if one is found, for
//   the successor and swaps them, then reverses the suffix pair by pair, all on the buffer RAM.
// Emit: each result takes a registered RAM read, then a load into the output register.
// Reset: synchronous, active low; clears the sequencer, count, overflow mark and output valid.
//   The element buffer is not cleared, as an entry is only read once it has been written.
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_core
// Buffers a streamed sequence and returns its next lexicographic permutation.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation_core #(
  parameter int MAX_LEN    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: one element per request, tlast closes the sequence.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] element_value
  input  logic        in_tlast,   // is_last
  // Result stream: one element of the permutation per request.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] out_value
  output logic        out_tlast,  // out_last
  output logic [1:0]  out_tuser   // [0] found_next, [1] overflow
);

  nlp_pkg::dp_cmd_t  cmd;
  nlp_pkg::dp_stat_t stat;
  logic              found, ovf;

  // The sequencer walks the buffer one step a cycle, but emit waits for a free
  // output register; it takes new requests only while loading, and the output
  // register lets the final result wait while the next sequence starts to load.
  nlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath owns the element buffer, all pointers and the output register.
  nlp_datapath #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_value  (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_last  (out_tlast),
    .out_found (found),
    .out_ovf   (ovf)
  );

  assign out_tuser = {ovf, found};

endmodule

// ----- design/nlp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_checker
// Port-level checks of the permutation core, bound to the top level.
// ----------------------------------------------------------------------------
module nlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed or was withdrawn");

  // A closing request makes the core busy in the next cycle.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted straight after a closing request");

  // While loading, at most the final result of the previous sequence waits.
  a_load_only_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(out_tvalid && !out_tlast))
    else $error("input accepted while a sequence was still being emitted");

  // A new result only appears right after the core was busy.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while the core was loading");

endmodule

bind next_lexicographic_permutation_core nlp_checker u_nlp_checker (.*);

// ----- test/tb_next_lexicographic_permutation_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_next_lexicographic_permutation_core
// Streams sequences into the permutation core and checks every result element.
// A local predictor buffers each accepted element, applies the next
// lexicographic permutation when a sequence closes and queues the expected
// results. These include the wrap to ascending order, single elements and
// sequences too long for the buffer. Both stream sides idle at random, and
// the idle rates change from phase to phase, down to none in the last.
// ----------------------------------------------------------------------------
module tb_next_lexicographic_permutation_core;

  localparam int VALUE_W  = nlp_pkg::VALUE_W;
  localparam int MAX_LEN  = 16;
  localparam int CLK_HALF = 6;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } elem_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               found;
    logic               ovf;
  } perm_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata = '0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;
  logic               out_tlast;
  logic [1:0]         out_tuser;

  elem_req_t    elem_reqs[$];
  perm_result_t perm_results[$];

  // Predictor state: the elements of the open sequence and its overflow mark.
  logic [VALUE_W-1:0] held_elems[MAX_LEN];
  int                 held_count = 0;
  logic               held_ovf = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int queued_items = 0;
  int mismatches = 0;

  next_lexicographic_permutation_core #(
    .MAX_LEN   (MAX_LEN),
    .ELEM_WIDTH(VALUE_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void reverse_span(input int lo, input int hi);
    logic [VALUE_W-1:0] t;
    while (lo < hi) begin
      t = held_elems[lo];
      held_elems[lo] = held_elems[hi];
      held_elems[hi] = t;
      lo++;
      hi--;
    end
  endfunction

  // Rearranges the held elements into their successor; returns 0 for under two elements
  // or when the sequence was already the last ordering and wrapped round to ascending.
  function automatic logic advance_permutation(input int n);
    int i;
    int p;
    int j;
    logic [VALUE_W-1:0] t;
    if (n < 2) return 1'b0;
    for (i = n - 1; i > 0; i--) begin
      p = i - 1;
      if (held_elems[p] < held_elems[i]) begin
        j = n - 1;
        while (j > p && !(held_elems[p] < held_elems[j])) j--;
        t = held_elems[p];
        held_elems[p] = held_elems[j];
        held_elems[j] = t;
        reverse_span(i, n - 1);
        return 1'b1;
      end
    end
    reverse_span(0, n - 1);
    return 1'b0;
  endfunction

  // Takes one accepted element request; a closing request yields the whole
  // permuted sequence as expected results.
  function automatic void absorb_element(input logic [VALUE_W-1:0] value, input logic last);
    logic         found;
    perm_result_t res;
    if (held_count < MAX_LEN) begin
      held_elems[held_count] = value;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (last) begin
      found = advance_permutation(held_count);
      for (int k = 0; k < held_count; k++) begin
        res.value = held_elems[k];
        res.last  = (k == held_count - 1);
        res.found = found;
        res.ovf   = held_ovf;
        perm_results.push_back(res);
      end
      held_count = 0;
      held_ovf   = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Driver: a new request is presented only once the previous one has been
  // taken, and each signal receives a single assignment per edge.
  always @(posedge clk) begin : drive_elements
    elem_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) absorb_element(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (elem_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          req = elem_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= req.value;
          in_tlast  <= req.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result taken is matched against the oldest expectation.
  always @(posedge clk) begin : watch_results
    perm_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (perm_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result %h arrived, expected none, actual value %h", $time,
                   {out_tdata, out_tlast, out_tuser}, out_tdata);
        end else begin
          want = perm_results.pop_front();
          check_field("value", want.value, out_tdata);
          check_field("last", VALUE_W'(want.last), VALUE_W'(out_tlast));
          check_field("found_next", VALUE_W'(want.found), VALUE_W'(out_tuser[0]));
          check_field("overflow", VALUE_W'(want.ovf), VALUE_W'(out_tuser[1]));
        end
      end
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic add_element(input logic [VALUE_W-1:0] value, input logic last);
    elem_req_t req;
    req.value = value;
    req.last  = last;
    elem_reqs.push_back(req);
    queued_items++;
  endtask

  // Mostly short sequences, some up to the buffer size, a few that overflow.
  // Small alphabets give repeated values; a descending sort hits the wrap case.
  task automatic add_random_sequence();
    logic [VALUE_W-1:0] vals[20];
    logic [VALUE_W-1:0] t;
    int len;
    int pick;
    int alpha;
    int order;
    pick  = $urandom_range(99, 0);
    len   = (pick < 70) ? $urandom_range(6, 1) :
            (pick < 90) ? $urandom_range(16, 7) : $urandom_range(20, 17);
    alpha = $urandom_range(2, 0);
    order = $urandom_range(5, 0);
    for (int k = 0; k < len; k++) begin
      case (alpha)
        0: vals[k] = VALUE_W'($urandom);
        1: vals[k] = VALUE_W'($urandom_range(3, 0));
        default: begin
          pick = $urandom_range(2, 0);
          vals[k] = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        end
      endcase
    end
    if (order < 2) begin
      for (int a = 0; a < len - 1; a++) begin
        for (int b = 0; b < len - 1 - a; b++) begin
          if ((order == 0) ? (vals[b] < vals[b+1]) : (vals[b] > vals[b+1])) begin
            t = vals[b];
            vals[b] = vals[b+1];
            vals[b+1] = t;
          end
        end
      end
    end
    for (int k = 0; k < len; k++) add_element(vals[k], k == len - 1);
  endtask

  task automatic wait_drained();
    while (elem_reqs.size() > 0 || in_tvalid || perm_results.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests: a single zero element, a two-element swap, a
    // descending run that wraps, equal elements, and a full buffer
    // whose closing element is dropped.
    send_idle_pct = 8;
    recv_idle_pct = 49;
    add_element(16'h0000, 1'b1);
    add_element(16'h0000, 1'b0);
    add_element(16'hFFFF, 1'b1);
    add_element(16'hFFFF, 1'b0);
    add_element(16'h8000, 1'b0);
    add_element(16'h0000, 1'b1);
    add_element(16'h0007, 1'b0);
    add_element(16'h0007, 1'b1);
    for (int k = 0; k < MAX_LEN; k++) add_element(16'(k * 16'h1111), 1'b0);
    add_element(16'hABCD, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      queued_items = 0;
      while (queued_items < 85) add_random_sequence();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("next_lexicographic_permutation_core test passed");
    end else begin
      $display("next_lexicographic_permutation_core test failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest plausible run.
  initial begin
    #5ms;
    $display("next_lexicographic_permutation_core test failed");
    $finish;
  end

endmodule
